/* hw/rtl/kabf_pkg.sv */
`timescale 1ns / 1ps

package kabf_pkg;

    localparam int unsigned VAL_W     = 48;
    localparam int unsigned PROD_W    = 96;
    localparam int unsigned DIVN_W    = 80;
    localparam int unsigned MUL_STEPS = 48;
    localparam int unsigned DIV_STEPS = 80;

    localparam logic [1:0] CFG_NOISE_ANGLE = 2'd0;
    localparam logic [1:0] CFG_NOISE_BIAS  = 2'd1;
    localparam logic [1:0] CFG_NOISE_MEAS  = 2'd2;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL16,
        OP_MUL32,
        OP_DIV,
        OP_END
    } op_t;

    // Operand and destination selectors of the sequencer.
    typedef enum logic [4:0] {
        SEL_ANG,
        SEL_BIAS,
        SEL_P00,
        SEL_P01,
        SEL_P10,
        SEL_P11,
        SEL_RIN,
        SEL_MEAS,
        SEL_DT,
        SEL_QA,
        SEL_QB,
        SEL_R,
        SEL_T,
        SEL_M,
        SEL_P11DT,
        SEL_S,
        SEL_K0,
        SEL_K1,
        SEL_Y
    } sel_t;

    typedef struct packed {
        op_t  op;
        sel_t a;
        sel_t b;
        sel_t dst;
    } uop_t;

    // Program of one filter update; the result of a multiply or divide goes to dst.
    function automatic uop_t program_word(input logic [4:0] pc);
        uop_t w;
        unique case (pc)
            5'd0:    w = '{OP_SUB,   SEL_RIN,   SEL_BIAS,  SEL_T};
            5'd1:    w = '{OP_MUL16, SEL_T,     SEL_DT,    SEL_M};
            5'd2:    w = '{OP_ADD,   SEL_ANG,   SEL_M,     SEL_ANG};
            5'd3:    w = '{OP_MUL16, SEL_P11,   SEL_DT,    SEL_P11DT};
            5'd4:    w = '{OP_SUB,   SEL_P11DT, SEL_P01,   SEL_T};
            5'd5:    w = '{OP_SUB,   SEL_T,     SEL_P10,   SEL_T};
            5'd6:    w = '{OP_ADD,   SEL_T,     SEL_QA,    SEL_T};
            5'd7:    w = '{OP_MUL16, SEL_T,     SEL_DT,    SEL_M};
            5'd8:    w = '{OP_ADD,   SEL_P00,   SEL_M,     SEL_P00};
            5'd9:    w = '{OP_SUB,   SEL_P01,   SEL_P11DT, SEL_P01};
            5'd10:   w = '{OP_SUB,   SEL_P10,   SEL_P11DT, SEL_P10};
            5'd11:   w = '{OP_MUL16, SEL_QB,    SEL_DT,    SEL_M};
            5'd12:   w = '{OP_ADD,   SEL_P11,   SEL_M,     SEL_P11};
            5'd13:   w = '{OP_ADD,   SEL_P00,   SEL_R,     SEL_S};
            5'd14:   w = '{OP_DIV,   SEL_P00,   SEL_S,     SEL_K0};
            5'd15:   w = '{OP_DIV,   SEL_P10,   SEL_S,     SEL_K1};
            5'd16:   w = '{OP_SUB,   SEL_MEAS,  SEL_ANG,   SEL_Y};
            5'd17:   w = '{OP_MUL32, SEL_K0,    SEL_Y,     SEL_M};
            5'd18:   w = '{OP_ADD,   SEL_ANG,   SEL_M,     SEL_ANG};
            5'd19:   w = '{OP_MUL32, SEL_K1,    SEL_Y,     SEL_M};
            5'd20:   w = '{OP_ADD,   SEL_BIAS,  SEL_M,     SEL_BIAS};
            5'd21:   w = '{OP_MUL32, SEL_K1,    SEL_P00,   SEL_M};
            5'd22:   w = '{OP_SUB,   SEL_P10,   SEL_M,     SEL_P10};
            5'd23:   w = '{OP_MUL32, SEL_K1,    SEL_P01,   SEL_M};
            5'd24:   w = '{OP_SUB,   SEL_P11,   SEL_M,     SEL_P11};
            5'd25:   w = '{OP_MUL32, SEL_K0,    SEL_P00,   SEL_M};
            5'd26:   w = '{OP_SUB,   SEL_P00,   SEL_M,     SEL_P00};
            5'd27:   w = '{OP_MUL32, SEL_K0,    SEL_P01,   SEL_M};
            5'd28:   w = '{OP_SUB,   SEL_P01,   SEL_M,     SEL_P01};
            default: w = '{OP_END,   SEL_ANG,   SEL_ANG,   SEL_ANG};
        endcase
        return w;
    endfunction

    // Saturating add or subtract on Q16.32 values.
    function automatic val_t sat_add(input val_t a, input val_t b, input logic sub);
        logic signed [VAL_W:0] s;
        s = sub ? ({a[VAL_W-1], a} - {b[VAL_W-1], b}) : ({a[VAL_W-1], a} + {b[VAL_W-1], b});
        if (s[VAL_W] != s[VAL_W-1])
            return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return s[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] magnitude(input val_t v);
        return v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Applies the sign to a magnitude and clamps to the signed 48-bit range.
    function automatic val_t sat_signed(input logic neg, input logic [VAL_W-1:0] m,
                                        input logic over);
        logic [VAL_W-1:0] lim;
        logic [VAL_W-1:0] mm;
        lim = neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        mm  = (over || m > lim) ? lim : m;
        return neg ? (~mm + 1'b1) : mm;
    endfunction

endpackage

/* hw/rtl/kalman_angle_bias_filter_top.sv */
`timescale 1ns / 1ps
// An accepted word runs the update program (17 add steps, 10 multiplies, 2 divides, 1 end
// step) and then loads the output register; an overwrite word goes straight to the output
// step. The block takes no new word until it has finished the last one, as the multiplies
// and divides run on the shared shift-add multiplier and restoring divider; a stalled
// result word holds the block until it leaves.
// Reset (rst_n low, asynchronous) clears the estimates and covariance and loads the noise defaults.

module kalman_angle_bias_filter_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [24:0] measured_angle,
    input  logic signed [24:0] gyro_rate,
    input  logic [16:0]        time_step,
    input  logic               overwrite,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [24:0] filtered_angle
);

    localparam int unsigned W = kabf_pkg::VAL_W;

    kabf_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [31:0] qa_reg, qb_reg, r_reg;

    // Filter state, all Q16.32.
    kabf_pkg::val_t ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    kabf_pkg::val_t ang_next, bias_next, p00_next, p01_next, p10_next, p11_next;

    // Latched input word, already in Q16.32 or Q1.16.
    kabf_pkg::val_t rin_reg, meas_reg;
    logic [16:0]    dt_reg;

    // Temporaries of the update program.
    kabf_pkg::val_t t_reg, m_reg, p11dt_reg, s_reg, k0_reg, k1_reg, y_reg;
    kabf_pkg::val_t t_next, m_next, p11dt_next, s_next, k0_next, k1_next, y_next;

    // Sequencer and shared arithmetic unit.
    logic [4:0]                    pc_reg, pc_next;
    logic [6:0]                    cnt_reg, cnt_next;
    logic [kabf_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [W-1:0]                  opd_reg, opd_next;
    logic                          neg_reg, neg_next;
    logic                          shift32_reg, shift32_next;
    logic [W:0]                    rem_reg, rem_next;
    logic [kabf_pkg::DIVN_W-1:0]   num_reg, num_next;
    kabf_pkg::sel_t                dst_reg, dst_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic signed [24:0] out_reg, out_next;

    kabf_pkg::uop_t uop;
    kabf_pkg::val_t opa, opb;
    logic           in_accept;
    logic           out_free;

    assign uop       = kabf_pkg::program_word(pc_reg);
    assign in_stall  = (state_reg != kabf_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign filtered_angle = out_reg;

    function automatic kabf_pkg::val_t pick(
        input kabf_pkg::sel_t sel,
        input kabf_pkg::val_t ang, input kabf_pkg::val_t bias,
        input kabf_pkg::val_t p00, input kabf_pkg::val_t p01,
        input kabf_pkg::val_t p10, input kabf_pkg::val_t p11,
        input kabf_pkg::val_t rin, input kabf_pkg::val_t meas,
        input logic [16:0] dt, input logic [31:0] qa,
        input logic [31:0] qb, input logic [31:0] r,
        input kabf_pkg::val_t t, input kabf_pkg::val_t m,
        input kabf_pkg::val_t p11dt, input kabf_pkg::val_t s,
        input kabf_pkg::val_t k0, input kabf_pkg::val_t k1,
        input kabf_pkg::val_t y);
        kabf_pkg::val_t v;
        unique case (sel)
            kabf_pkg::SEL_ANG:   v = ang;
            kabf_pkg::SEL_BIAS:  v = bias;
            kabf_pkg::SEL_P00:   v = p00;
            kabf_pkg::SEL_P01:   v = p01;
            kabf_pkg::SEL_P10:   v = p10;
            kabf_pkg::SEL_P11:   v = p11;
            kabf_pkg::SEL_RIN:   v = rin;
            kabf_pkg::SEL_MEAS:  v = meas;
            kabf_pkg::SEL_DT:    v = {{(kabf_pkg::VAL_W-17){1'b0}}, dt};
            kabf_pkg::SEL_QA:    v = {{(kabf_pkg::VAL_W-32){1'b0}}, qa};
            kabf_pkg::SEL_QB:    v = {{(kabf_pkg::VAL_W-32){1'b0}}, qb};
            kabf_pkg::SEL_R:     v = {{(kabf_pkg::VAL_W-32){1'b0}}, r};
            kabf_pkg::SEL_T:     v = t;
            kabf_pkg::SEL_M:     v = m;
            kabf_pkg::SEL_P11DT: v = p11dt;
            kabf_pkg::SEL_S:     v = s;
            kabf_pkg::SEL_K0:    v = k0;
            kabf_pkg::SEL_K1:    v = k1;
            kabf_pkg::SEL_Y:     v = y;
            default:             v = '0;
        endcase
        return v;
    endfunction

    assign opa = pick(uop.a, ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg,
                      rin_reg, meas_reg, dt_reg, qa_reg, qb_reg, r_reg, t_reg, m_reg,
                      p11dt_reg, s_reg, k0_reg, k1_reg, y_reg);
    assign opb = pick(uop.b, ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg,
                      rin_reg, meas_reg, dt_reg, qa_reg, qb_reg, r_reg, t_reg, m_reg,
                      p11dt_reg, s_reg, k0_reg, k1_reg, y_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kabf_pkg::ST_IDLE:
            begin
                if (in_accept)
                    state_next = overwrite ? kabf_pkg::ST_FINISH : kabf_pkg::ST_ISSUE;
            end
            kabf_pkg::ST_ISSUE:
            begin
                unique case (uop.op)
                    kabf_pkg::OP_MUL16, kabf_pkg::OP_MUL32: state_next = kabf_pkg::ST_MUL;
                    kabf_pkg::OP_DIV:                       state_next = kabf_pkg::ST_DIV;
                    kabf_pkg::OP_END:                       state_next = kabf_pkg::ST_FINISH;
                    default:                                state_next = kabf_pkg::ST_ISSUE;
                endcase
            end
            kabf_pkg::ST_MUL:
            begin
                if (cnt_reg == 7'(kabf_pkg::MUL_STEPS))
                    state_next = kabf_pkg::ST_ISSUE;
            end
            kabf_pkg::ST_DIV:
            begin
                if (cnt_reg == 7'(kabf_pkg::DIV_STEPS))
                    state_next = kabf_pkg::ST_ISSUE;
            end
            kabf_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = kabf_pkg::ST_IDLE;
            end
            default: state_next = kabf_pkg::ST_IDLE;
        endcase
    end

    // Datapath: at most one write per cycle into the selected register.
    always_comb
    begin
        kabf_pkg::val_t   wval;
        logic             wen;
        logic [W:0]       msum;
        logic [W:0]       rsh;
        logic             qbit;
        logic [W-1:0]     mmag;
        logic             mover;
        logic [W-1:0]     amag;
        logic [31:0]      omag;

        ang_next = ang_reg;   bias_next = bias_reg;
        p00_next = p00_reg;   p01_next = p01_reg;
        p10_next = p10_reg;   p11_next = p11_reg;
        t_next = t_reg;       m_next = m_reg;       p11dt_next = p11dt_reg;
        s_next = s_reg;       k0_next = k0_reg;     k1_next = k1_reg;  y_next = y_reg;
        pc_next = pc_reg;     cnt_next = cnt_reg;
        prod_next = prod_reg; opd_next = opd_reg;   neg_next = neg_reg;
        shift32_next = shift32_reg;
        rem_next = rem_reg;   num_next = num_reg;   dst_next = dst_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next = out_reg;
        wval = '0;
        wen  = 1'b0;
        msum = '0;
        rsh  = '0;
        qbit = 1'b0;
        mmag = '0;
        mover = 1'b0;
        amag = '0;
        omag = '0;

        unique case (state_reg)
            kabf_pkg::ST_IDLE:
            begin
                pc_next = '0;
                if (in_accept && overwrite)
                    ang_next = {{(W-41){measured_angle[24]}}, measured_angle, 16'd0};
            end
            kabf_pkg::ST_ISSUE:
            begin
                dst_next = uop.dst;
                cnt_next = '0;
                neg_next = opa[W-1] ^ opb[W-1];
                unique case (uop.op)
                    kabf_pkg::OP_ADD, kabf_pkg::OP_SUB:
                    begin
                        wval = kabf_pkg::sat_add(opa, opb, uop.op == kabf_pkg::OP_SUB);
                        wen = 1'b1;
                        pc_next = pc_reg + 5'd1;
                    end
                    kabf_pkg::OP_MUL16, kabf_pkg::OP_MUL32:
                    begin
                        opd_next = kabf_pkg::magnitude(opa);
                        prod_next = {{(kabf_pkg::PROD_W-W){1'b0}}, kabf_pkg::magnitude(opb)};
                        shift32_next = (uop.op == kabf_pkg::OP_MUL32);
                    end
                    kabf_pkg::OP_DIV:
                    begin
                        opd_next = kabf_pkg::magnitude(opb);
                        num_next = {kabf_pkg::magnitude(opa), 32'd0};
                        rem_next = '0;
                    end
                    default: pc_next = pc_reg;
                endcase
            end
            kabf_pkg::ST_MUL:
            begin
                if (cnt_reg == 7'(kabf_pkg::MUL_STEPS))
                begin
                    if (shift32_reg)
                    begin
                        mmag = prod_reg[79:32];
                        mover = |prod_reg[95:80];
                    end
                    else
                    begin
                        mmag = prod_reg[63:16];
                        mover = |prod_reg[95:64];
                    end
                    wval = kabf_pkg::sat_signed(neg_reg, mmag, mover);
                    wen = 1'b1;
                    pc_next = pc_reg + 5'd1;
                end
                else
                begin
                    // Shift-add step: add the multiplicand on a set low bit, shift right.
                    msum = {1'b0, prod_reg[kabf_pkg::PROD_W-1:W]} +
                           (prod_reg[0] ? {1'b0, opd_reg} : {(W+1){1'b0}});
                    prod_next = {msum, prod_reg[W-1:1]};
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            kabf_pkg::ST_DIV:
            begin
                if (cnt_reg == 7'(kabf_pkg::DIV_STEPS))
                begin
                    // A zero innovation variance gives a zero gain.
                    if (opd_reg == '0)
                        wval = '0;
                    else
                        wval = kabf_pkg::sat_signed(neg_reg, num_reg[W-1:0],
                                                    |num_reg[kabf_pkg::DIVN_W-1:W]);
                    wen = 1'b1;
                    pc_next = pc_reg + 5'd1;
                end
                else
                begin
                    // Restoring step: one quotient bit per cycle.
                    rsh = {rem_reg[W-1:0], num_reg[kabf_pkg::DIVN_W-1]};
                    qbit = (rsh >= {1'b0, opd_reg});
                    rem_next = qbit ? (rsh - {1'b0, opd_reg}) : rsh;
                    num_next = {num_reg[kabf_pkg::DIVN_W-2:0], qbit};
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            kabf_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    // Truncate toward zero to Q9.16 and clamp to the 25-bit range.
                    amag = kabf_pkg::magnitude(ang_reg);
                    omag = amag[W-1:16];
                    if (ang_reg[W-1])
                        out_next = (omag > 32'h0100_0000) ? 25'sh100_0000
                                                          : 25'(~omag + 32'd1);
                    else
                        out_next = (omag > 32'h00FF_FFFF) ? 25'sh0FF_FFFF : 25'(omag);
                    out_valid_next = 1'b1;
                end
            end
            default: pc_next = '0;
        endcase

        if (wen)
        begin
            unique case (dst_next)
                kabf_pkg::SEL_ANG:   ang_next = wval;
                kabf_pkg::SEL_BIAS:  bias_next = wval;
                kabf_pkg::SEL_P00:   p00_next = wval;
                kabf_pkg::SEL_P01:   p01_next = wval;
                kabf_pkg::SEL_P10:   p10_next = wval;
                kabf_pkg::SEL_P11:   p11_next = wval;
                kabf_pkg::SEL_T:     t_next = wval;
                kabf_pkg::SEL_M:     m_next = wval;
                kabf_pkg::SEL_P11DT: p11dt_next = wval;
                kabf_pkg::SEL_S:     s_next = wval;
                kabf_pkg::SEL_K0:    k0_next = wval;
                kabf_pkg::SEL_K1:    k1_next = wval;
                kabf_pkg::SEL_Y:     y_next = wval;
                default:             m_next = m_reg;
            endcase
        end
    end

    // Control and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kabf_pkg::ST_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            qa_reg        <= 32'd4294967;
            qb_reg        <= 32'd12884902;
            r_reg         <= 32'd128849019;
            ang_reg       <= '0;
            bias_reg      <= '0;
            p00_reg       <= '0;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            ang_reg       <= ang_next;
            bias_reg      <= bias_next;
            p00_reg       <= p00_next;
            p01_reg       <= p01_next;
            p10_reg       <= p10_next;
            p11_reg       <= p11_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    kabf_pkg::CFG_NOISE_ANGLE: qa_reg <= cfg_data;
                    kabf_pkg::CFG_NOISE_BIAS:  qb_reg <= cfg_data;
                    kabf_pkg::CFG_NOISE_MEAS:  r_reg  <= cfg_data;
                    default:                   r_reg  <= r_reg;
                endcase
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rin_reg  <= {{(W-41){gyro_rate[24]}}, gyro_rate, 16'd0};
            meas_reg <= {{(W-41){measured_angle[24]}}, measured_angle, 16'd0};
            dt_reg   <= time_step;
        end
        t_reg        <= t_next;
        m_reg        <= m_next;
        p11dt_reg    <= p11dt_next;
        s_reg        <= s_next;
        k0_reg       <= k0_next;
        k1_reg       <= k1_next;
        y_reg        <= y_next;
        prod_reg     <= prod_next;
        opd_reg      <= opd_next;
        neg_reg      <= neg_next;
        shift32_reg  <= shift32_next;
        rem_reg      <= rem_next;
        num_reg      <= num_next;
        dst_reg      <= dst_next;
        out_reg      <= out_next;
    end

endmodule
